FILE: hw/rtl/ulf_pkg.sv
// ----------------------------------------------------------------------------
// ulf_pkg
// Shared opcodes, instruction field positions and widths for the unaligned
// load fixup block.
// ----------------------------------------------------------------------------
package ulf_pkg;

	localparam int unsigned OpLsb  = 26;
	localparam int unsigned OpMsb  = 31;
	localparam int unsigned RegLsb = 21;
	localparam int unsigned RegMsb = 25;

	typedef logic [5:0]  opcode_t;
	typedef logic [4:0]  regnum_t;
	typedef logic [31:0] word_t;
	typedef logic [63:0] dword_t;

	localparam opcode_t OP_LDWU = 6'h0c;
	localparam opcode_t OP_LDL  = 6'h28;
	localparam opcode_t OP_LDS  = 6'h22;

	// exponent rebias from single (127) to double (1023)
	localparam logic [10:0] EXP_REBIAS = 11'd896;
	// exponent of a normalised denormal: leading one position plus this
	localparam logic [10:0] EXP_DENORM = 11'd874;

endpackage

FILE: hw/rtl/ulf_widen.sv
// ----------------------------------------------------------------------------
// ulf_widen
// Widens an IEEE single to IEEE double bits: denormals are normalised,
// zeros keep their sign, infinities stay infinite and NaNs are quietened.
// ----------------------------------------------------------------------------
module ulf_widen (
	input  ulf_pkg::word_t  single_bits,
	output ulf_pkg::dword_t double_bits
);

	logic        sign;
	logic [7:0]  exp_s;
	logic [22:0] mant;
	logic [4:0]  lead;
	logic [4:0]  lz;
	logic [22:0] norm;
	logic [10:0] exp_d;
	logic [51:0] frac_d;

	assign sign  = single_bits[31];
	assign exp_s = single_bits[30:23];
	assign mant  = single_bits[22:0];

	// position of the leading one in the mantissa
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (mant[i]) begin
				lead = 5'(i);
			end
		end
	end

	assign lz   = 5'd22 - lead;
	assign norm = mant << lz;

	always_comb begin
		if (exp_s == 8'hff) begin
			exp_d  = 11'h7ff;
			frac_d = {mant, 29'd0};
			if (mant != 23'd0) begin
				frac_d[51] = 1'b1;
			end
		end else if (exp_s == 8'h00) begin
			if (mant == 23'd0) begin
				exp_d  = 11'd0;
				frac_d = 52'd0;
			end else begin
				// drop the hidden one that now sits at the top
				exp_d  = {6'd0, lead} + ulf_pkg::EXP_DENORM;
				frac_d = {norm[21:0], 1'b0, 29'd0};
			end
		end else begin
			exp_d  = {3'd0, exp_s} + ulf_pkg::EXP_REBIAS;
			frac_d = {mant, 29'd0};
		end
	end

	assign double_bits = {sign, exp_d, frac_d};

endmodule

FILE: hw/rtl/unaligned_load_fixup_top.sv
// ----------------------------------------------------------------------------
// unaligned_load_fixup_top
// Repairs a big-endian load that trapped on a misaligned address.
// ----------------------------------------------------------------------------
// One result comes out per fault: the input beat is registered, then
// decode, funnel shift and formatting run combinationally into the result
// register. A new fault is taken in every cycle, so busy never
// goes high. Results appear for a single cycle with done high and cannot be
// held off: the receiver must take each one as it comes.
module unaligned_load_fixup_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ulf_pkg::word_t   instruction,
	input  ulf_pkg::dword_t  pc,
	input  ulf_pkg::dword_t  fault_address,
	input  ulf_pkg::word_t   word_first,
	input  ulf_pkg::word_t   word_second,
	output logic             done,
	output ulf_pkg::dword_t  aligned_address,
	output ulf_pkg::regnum_t target_register,
	output logic             to_float_file,
	output ulf_pkg::dword_t  load_value,
	output ulf_pkg::dword_t  next_pc,
	output logic             status
);

	logic             valid_s1;
	ulf_pkg::word_t   insn_s1;
	ulf_pkg::dword_t  pc_s1;
	ulf_pkg::dword_t  fault_s1;
	ulf_pkg::word_t   w0_s1;
	ulf_pkg::word_t   w1_s1;

	logic             valid_s2;
	ulf_pkg::dword_t  addr_s2;
	ulf_pkg::regnum_t reg_s2;
	logic             float_s2;
	ulf_pkg::dword_t  value_s2;
	ulf_pkg::dword_t  npc_s2;
	logic             status_s2;

	ulf_pkg::opcode_t op;
	ulf_pkg::dword_t  ea;
	ulf_pkg::word_t   word;
	ulf_pkg::dword_t  wide;
	ulf_pkg::dword_t  value;
	logic             to_float;
	logic             unknown;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			insn_s1  <= instruction;
			pc_s1    <= pc;
			fault_s1 <= fault_address;
			w0_s1    <= word_first;
			w1_s1    <= word_second;
		end
	end

	assign op = insn_s1[ulf_pkg::OpMsb:ulf_pkg::OpLsb];

	// LDWU addresses the other halfword of the word
	assign ea = (op == ulf_pkg::OP_LDWU) ? (fault_s1 ^ 64'd2) : fault_s1;

	always_comb begin
		case (ea[1:0])
			2'd0:    word = w0_s1;
			2'd1:    word = {w0_s1[23:0], w1_s1[31:24]};
			2'd2:    word = {w0_s1[15:0], w1_s1[31:16]};
			default: word = {w0_s1[7:0], w1_s1[31:8]};
		endcase
	end

	ulf_widen u_widen (
		.single_bits (word),
		.double_bits (wide)
	);

	always_comb begin
		value    = 64'd0;
		to_float = 1'b0;
		unknown  = 1'b0;
		case (op)
			ulf_pkg::OP_LDWU: value = {48'd0, word[31:16]};
			ulf_pkg::OP_LDL:  value = {{32{word[31]}}, word};
			ulf_pkg::OP_LDS: begin
				value    = wide;
				to_float = 1'b1;
			end
			default: unknown = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			addr_s2   <= {ea[63:2], 2'b00};
			reg_s2    <= insn_s1[ulf_pkg::RegMsb:ulf_pkg::RegLsb];
			float_s2  <= to_float;
			value_s2  <= value;
			npc_s2    <= pc_s1 + 64'd4;
			status_s2 <= unknown;
		end
	end

	assign done            = valid_s2;
	assign aligned_address = addr_s2;
	assign target_register = reg_s2;
	assign to_float_file   = float_s2;
	assign load_value      = value_s2;
	assign next_pc         = npc_s2;
	assign status          = status_s2;

endmodule

FILE: hw/rtl/ulf_chk.sv
// ----------------------------------------------------------------------------
// ulf_chk
// Port-level checks for the unaligned load fixup block, bound to the top.
// ----------------------------------------------------------------------------
module ulf_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input ulf_pkg::word_t   instruction,
	input ulf_pkg::dword_t  pc,
	input ulf_pkg::dword_t  fault_address,
	input ulf_pkg::word_t   word_first,
	input ulf_pkg::word_t   word_second,
	input logic             done,
	input ulf_pkg::dword_t  aligned_address,
	input ulf_pkg::regnum_t target_register,
	input logic             to_float_file,
	input ulf_pkg::dword_t  load_value,
	input ulf_pkg::dword_t  next_pc,
	input logic             status
);

	// every accepted beat yields its result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted beat produced no result");

	// no result without an earlier accepted beat
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted beat");

	a_next_pc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> next_pc == $past(pc, 2) + 64'd4)
		else $error("next_pc does not match pc of the beat");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !to_float_file && load_value == 64'd0
			&& aligned_address == {$past(fault_address[63:2], 2), 2'b00})
		else $error("unknown opcode result not cleared");

endmodule

bind unaligned_load_fixup_top ulf_chk u_ulf_chk (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for unaligned_load_fixup_top. Directed faults hit every
// load kind, each byte offset, wrapping pc values and the single-float
// specials; random faults then run under several sender idling patterns.
// Every accepted fault is predicted and checked field by field on done.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_BEATS = 400;
	localparam int unsigned DRAIN_CYCLES = 8;
	// double exponent for a single of exponent e is e + (1023 - 127)
	localparam int unsigned BIAS_GAP     = 1023 - 127;
	// leading one of a denormal at bit p scales to 2^(p - 149)
	localparam int unsigned DENORM_BASE  = 1023 - 149;

	typedef struct {
		ulf_pkg::word_t  instruction;
		ulf_pkg::dword_t pc;
		ulf_pkg::dword_t fault_address;
		ulf_pkg::word_t  word_first;
		ulf_pkg::word_t  word_second;
		int unsigned     idle_pct;
	} fault_beat_t;

	typedef struct {
		ulf_pkg::dword_t  aligned_address;
		ulf_pkg::regnum_t target_register;
		logic             to_float_file;
		ulf_pkg::dword_t  load_value;
		ulf_pkg::dword_t  next_pc;
		logic             status;
	} fixup_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	ulf_pkg::word_t   instruction = '0;
	ulf_pkg::dword_t  pc = '0;
	ulf_pkg::dword_t  fault_address = '0;
	ulf_pkg::word_t   word_first = '0;
	ulf_pkg::word_t   word_second = '0;
	logic             done;
	ulf_pkg::dword_t  aligned_address;
	ulf_pkg::regnum_t target_register;
	logic             to_float_file;
	ulf_pkg::dword_t  load_value;
	ulf_pkg::dword_t  next_pc;
	logic             status;

	fault_beat_t   fault_pending[$];
	fixup_result_t fixup_expected[$];
	int unsigned   gap_pct = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   beats_taken = 0;
	int unsigned   results_seen = 0;
	int unsigned   cycle_count = 0;
	int unsigned   ldwu_count = 0;
	int unsigned   ldl_count = 0;
	int unsigned   lds_count = 0;
	int unsigned   unknown_count = 0;

	unaligned_load_fixup_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.instruction     (instruction),
		.pc              (pc),
		.fault_address   (fault_address),
		.word_first      (word_first),
		.word_second     (word_second),
		.done            (done),
		.aligned_address (aligned_address),
		.target_register (target_register),
		.to_float_file   (to_float_file),
		.load_value      (load_value),
		.next_pc         (next_pc),
		.status          (status)
	);

	always #4 clk = ~clk;

	function automatic ulf_pkg::dword_t widen_single(ulf_pkg::word_t s);
		logic [7:0]  e;
		logic [22:0] m;
		logic [22:0] norm;
		logic [10:0] ex;
		logic [51:0] frac;
		int          p;
		e = s[30:23];
		m = s[22:0];
		if (e == 8'hff) begin
			ex = 11'h7ff;
			frac = {m, 29'd0};
			// quiet any NaN
			if (m != '0)
				frac[51] = 1'b1;
		end else if (e == '0) begin
			if (m == '0)
				return {s[31], 63'd0};
			p = 22;
			while (!m[p])
				p--;
			// drop the leading one off the top of the field
			norm = m << (23 - p);
			ex = 11'(p + DENORM_BASE);
			frac = {norm, 29'd0};
		end else begin
			ex = 11'(e + BIAS_GAP);
			frac = {m, 29'd0};
		end
		return {s[31], ex, frac};
	endfunction

	function automatic fixup_result_t fixup_predict(ulf_pkg::word_t insn,
			ulf_pkg::dword_t pc_in, ulf_pkg::dword_t fault, ulf_pkg::word_t w0,
			ulf_pkg::word_t w1);
		ulf_pkg::opcode_t op;
		ulf_pkg::dword_t  ea;
		ulf_pkg::dword_t  pair;
		ulf_pkg::word_t   window;
		fixup_result_t    r;
		op = insn[ulf_pkg::OpMsb:ulf_pkg::OpLsb];
		ea = fault;
		if (op == ulf_pkg::OP_LDWU)
			ea[1] = ~ea[1];
		pair = {w0, w1} << (8 * ea[1:0]);
		window = pair[63:32];
		r.aligned_address = {ea[63:2], 2'b00};
		r.target_register = insn[ulf_pkg::RegMsb:ulf_pkg::RegLsb];
		r.next_pc = pc_in + 64'd4;
		r.to_float_file = 1'b0;
		r.load_value = '0;
		r.status = 1'b0;
		case (op)
			ulf_pkg::OP_LDWU: r.load_value = {48'd0, window[31:16]};
			ulf_pkg::OP_LDL:  r.load_value = {{32{window[31]}}, window};
			ulf_pkg::OP_LDS: begin
				r.load_value = widen_single(window);
				r.to_float_file = 1'b1;
			end
			default: r.status = 1'b1;
		endcase
		return r;
	endfunction

	// Place the loaded word at the byte offset the block will shift by, so
	// that the formatting cases are hit on purpose rather than by luck.
	task automatic queue_fault(input ulf_pkg::opcode_t op, input ulf_pkg::regnum_t rd,
			input ulf_pkg::dword_t pc_v, input ulf_pkg::dword_t fault_v,
			input ulf_pkg::word_t window, input ulf_pkg::dword_t filler);
		fault_beat_t     b;
		logic [1:0]      off;
		ulf_pkg::dword_t pair;
		off = fault_v[1:0] ^ ((op == ulf_pkg::OP_LDWU) ? 2'b10 : 2'b00);
		pair = filler;
		pair[63 - 8 * off -: 32] = window;
		b.instruction = {op, rd, 21'($urandom)};
		b.pc = pc_v;
		b.fault_address = fault_v;
		b.word_first = pair[63:32];
		b.word_second = pair[31:0];
		b.idle_pct = gap_pct;
		fault_pending.push_back(b);
	endtask

	// Driver: hold the beat while busy, otherwise take the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		fault_beat_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			instruction <= '0;
			pc <= '0;
			fault_address <= '0;
			word_first <= '0;
			word_second <= '0;
		end else if (!start || !busy) begin
			if (start) begin
				fixup_expected.push_back(fixup_predict(instruction, pc, fault_address,
					word_first, word_second));
				beats_taken++;
				case (ulf_pkg::opcode_t'(instruction[ulf_pkg::OpMsb:ulf_pkg::OpLsb]))
					ulf_pkg::OP_LDWU: ldwu_count++;
					ulf_pkg::OP_LDL:  ldl_count++;
					ulf_pkg::OP_LDS:  lds_count++;
					default: unknown_count++;
				endcase
			end
			if (fault_pending.size() != 0 &&
					$urandom_range(99) >= fault_pending[0].idle_pct) begin
				nxt = fault_pending.pop_front();
				start <= 1'b1;
				instruction <= nxt.instruction;
				pc <= nxt.pc;
				fault_address <= nxt.fault_address;
				word_first <= nxt.word_first;
				word_second <= nxt.word_second;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done beat must match the oldest prediction.
	always @(posedge clk) begin
		fixup_result_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (fixup_expected.size() == 0) begin
				$error("result with no fault outstanding");
				mismatch_count++;
			end else begin
				exp_r = fixup_expected.pop_front();
				if (aligned_address !== exp_r.aligned_address) begin
					$error("aligned_address: expected %h, got %h",
						exp_r.aligned_address, aligned_address);
					mismatch_count++;
				end
				if (target_register !== exp_r.target_register) begin
					$error("target_register: expected %0d, got %0d",
						exp_r.target_register, target_register);
					mismatch_count++;
				end
				if (to_float_file !== exp_r.to_float_file) begin
					$error("to_float_file: expected %b, got %b",
						exp_r.to_float_file, to_float_file);
					mismatch_count++;
				end
				if (load_value !== exp_r.load_value) begin
					$error("load_value: expected %h, got %h", exp_r.load_value, load_value);
					mismatch_count++;
				end
				if (next_pc !== exp_r.next_pc) begin
					$error("next_pc: expected %h, got %h", exp_r.next_pc, next_pc);
					mismatch_count++;
				end
				if (status !== exp_r.status) begin
					$error("status: expected %b, got %b", exp_r.status, status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d predictions outstanding",
				CYCLE_LIMIT, fixup_expected.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned      gap_plan [4];
		ulf_pkg::opcode_t op;
		ulf_pkg::word_t   win;
		ulf_pkg::dword_t  pc_v;
		int unsigned      sel;
		int unsigned      k;
		gap_plan = '{0, 85, 16, 0};
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// LDWU and LDL at each byte offset, wrapping pc, extreme addresses
		for (k = 0; k < 4; k++) begin
			queue_fault(ulf_pkg::OP_LDWU, 5'd0, 64'hffff_ffff_ffff_fffc + k, 64'(k),
				32'h8765_4321, 64'hffff_ffff_ffff_ffff);
			queue_fault(ulf_pkg::OP_LDL, 5'd31, 64'(k), ~64'(3 - k),
				(k[0] ? 32'h8000_0000 : 32'h7fff_ffff), 64'h0);
		end
		queue_fault(ulf_pkg::OP_LDL, 5'd7, '1, 64'h0, 32'hffff_ffff, 64'h0);
		queue_fault(ulf_pkg::OP_LDWU, 5'd31, '0, '1, 32'hffff_0000,
			64'h0123_4567_89ab_cdef);
		// float specials: signed zeros, infinities, NaNs, denormals, range ends
		queue_fault(ulf_pkg::OP_LDS, 5'd1, 64'h100, 64'h1000, 32'h0000_0000, '1);
		queue_fault(ulf_pkg::OP_LDS, 5'd2, 64'h104, 64'h1001, 32'h8000_0000, '1);
		queue_fault(ulf_pkg::OP_LDS, 5'd3, 64'h108, 64'h1002, 32'h7f80_0000, '0);
		queue_fault(ulf_pkg::OP_LDS, 5'd4, 64'h10c, 64'h1003, 32'hff80_0000, '0);
		queue_fault(ulf_pkg::OP_LDS, 5'd5, 64'h110, 64'h2001, 32'h7f80_0001, '1);
		queue_fault(ulf_pkg::OP_LDS, 5'd6, 64'h114, 64'h2002, 32'hffc0_1234, '0);
		queue_fault(ulf_pkg::OP_LDS, 5'd7, 64'h118, 64'h2003, 32'h0000_0001, '1);
		queue_fault(ulf_pkg::OP_LDS, 5'd8, 64'h11c, 64'h2000, 32'h807f_ffff, '0);
		queue_fault(ulf_pkg::OP_LDS, 5'd9, 64'h120, 64'h3001, 32'h0080_0000, '1);
		queue_fault(ulf_pkg::OP_LDS, 5'd10, 64'h124, 64'h3002, 32'h7f7f_ffff, '0);
		queue_fault(ulf_pkg::OP_LDS, 5'd11, 64'h128, 64'h3003, 32'hc049_0fdb, '1);
		// opcodes the block must refuse
		queue_fault(6'h00, 5'd12, '1, 64'h5555_5555_5555_5557, 32'h1234_5678, '1);
		queue_fault(6'h3f, 5'd13, 64'h0, 64'haaaa_aaaa_aaaa_aaaa, 32'h9abc_def0, '0);

		for (k = 0; k < RANDOM_BEATS; k++) begin
			gap_pct = gap_plan[k / (RANDOM_BEATS / 4)];
			sel = $urandom_range(99);
			if (sel < 30)
				op = ulf_pkg::OP_LDWU;
			else if (sel < 60)
				op = ulf_pkg::OP_LDL;
			else if (sel < 85)
				op = ulf_pkg::OP_LDS;
			else
				op = ulf_pkg::opcode_t'($urandom);
			win = $urandom;
			if (op == ulf_pkg::OP_LDS) begin
				case ($urandom_range(9))
					0: win[30:23] = '0;
					1: win[30:23] = '1;
					2: begin
						win[30:23] = '0;
						win[22:0] = 23'($urandom) >> $urandom_range(22);
					end
					3: win[30:0] = '0;
					default: ;
				endcase
			end
			pc_v = ($urandom_range(7) == 0) ? ~64'($urandom_range(15))
				: {$urandom, $urandom};
			queue_fault(op, ulf_pkg::regnum_t'($urandom), pc_v, {$urandom, $urandom}, win,
				{$urandom, $urandom});
		end

		while (fault_pending.size() != 0 || start)
			@(posedge clk);
		while (fixup_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d faults taken, %0d results checked in %0d cycles", beats_taken,
			results_seen, cycle_count);
		$display("mix: %0d LDWU, %0d LDL, %0d LDS, %0d refused opcodes; idle 0/85/16%%",
			ldwu_count, ldl_count, lds_count, unknown_count);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ulf_pkg.sv
hw/rtl/ulf_widen.sv
hw/rtl/unaligned_load_fixup_top.sv
hw/rtl/ulf_chk.sv
tb/tb_top.sv
